// ----- src/avgp_pkg.sv -----
// Shared types and constants for the 2-D average pooling core.
// Used by the front end, the back end and the top level.
package avgp_pkg;

  // Plane store and datapath limits
  localparam int MAX_H      = 64;
  localparam int MAX_W      = 64;
  localparam int MAX_WINDOW = 16;
  localparam int PIXEL_BITS = 16;

  localparam int MEM_DEPTH = MAX_H * MAX_W;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int HB        = $clog2(MAX_H + 1);
  localparam int WB        = $clog2(MAX_W + 1);
  localparam int LENW      = $clog2(MAX_WINDOW + 1);
  localparam int AREAW     = 2 * LENW;
  localparam int SUMW      = PIXEL_BITS + 2 * $clog2(MAX_WINDOW);
  localparam int NW        = SUMW + 1;
  localparam int PRODW     = 12;
  localparam int CW        = 14;
  localparam int CFG_DW    = 8;
  localparam int CFG_IW    = 3;

  typedef enum logic [CFG_IW-1:0] {
    REG_IMAGE_HEIGHT  = 3'd0,
    REG_IMAGE_WIDTH   = 3'd1,
    REG_WINDOW_HEIGHT = 3'd2,
    REG_WINDOW_WIDTH  = 3'd3,
    REG_STEP_ROWS     = 3'd4,
    REG_STEP_COLS     = 3'd5,
    REG_PADDING       = 3'd6,
    REG_OPTIONS       = 3'd7
  } reg_index_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef struct packed {
    logic [6:0] image_height;
    logic [6:0] image_width;
    logic [4:0] window_height;
    logic [4:0] window_width;
    logic [4:0] step_rows;
    logic [4:0] step_cols;
    logic [7:0] padding;
    logic [1:0] options;
  } cfg_t;

  // One classified request from front to back
  typedef struct packed {
    logic                  query;
    logic                  zero;
    logic                  wr;
    logic [AW-1:0]         addr;
    logic [PIXEL_BITS-1:0] value;
    logic [HB-1:0]         hs;
    logic [HB-1:0]         he;
    logic [WB-1:0]         ws;
    logic [WB-1:0]         we;
    logic [AREAW-1:0]      area;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_DIVLD,
    ST_DIV,
    ST_OUT
  } back_state_t;

endpackage

// ----- src/avgp_if.sv -----
// Request and result channel interfaces of the average pooling core.
// Depends on nothing; field widths follow the request and result formats.
interface avgp_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic [5:0]        pixel_row;
  logic [5:0]        pixel_col;
  logic signed [15:0] pixel_value;
  logic [6:0]        out_row;
  logic [6:0]        out_col;

  modport source (output valid, func, pixel_row, pixel_col, pixel_value, out_row, out_col,
                  input ready);
  modport sink (input valid, func, pixel_row, pixel_col, pixel_value, out_row, out_col,
                output ready);
endinterface

interface avgp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] average;

  modport source (output valid, average, input ready);
  modport sink (input valid, average, output ready);
endinterface

// ----- src/avgp_front.sv -----
// Front end: accepts requests, works out window geometry, queues commands.
// Depends on avgp_pkg and avgp_in_if.
module avgp_front
  import avgp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  avgp_in_if.sink    pool_in,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  // Stage 1: products and load address
  logic                  s1_valid;
  logic                  s1_func;
  logic                  s1_wr;
  logic [AW-1:0]         s1_addr;
  logic [PIXEL_BITS-1:0] s1_value;
  logic [PRODW-1:0]      s1_prod_h;
  logic [PRODW-1:0]      s1_prod_w;

  // Two-entry queue
  cmd_t       q_mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       full;
  logic       push;
  logic       s1_ready;
  cmd_t       cmd_new;

  logic signed [CW-1:0] ih, iw, kh, kw, ph, pw;
  logic signed [CW-1:0] phs, pws, phe, pwe, hs, ws, he, we, lh, lw;
  logic                 nonempty;

  assign full     = (count == 2'd2);
  assign push     = s1_valid && !full;
  assign s1_ready = !s1_valid || !full;
  assign pool_in.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pool_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && pool_in.valid) begin
      s1_func   <= pool_in.func;
      s1_wr     <= (7'(pool_in.pixel_row) < 7'(MAX_H)) && (7'(pool_in.pixel_col) < 7'(MAX_W));
      s1_addr   <= AW'(AW'(pool_in.pixel_row) * AW'(MAX_W) + AW'(pool_in.pixel_col));
      s1_value  <= PIXEL_BITS'(pool_in.pixel_value);
      s1_prod_h <= PRODW'(pool_in.out_row) * PRODW'(cfg.step_rows);
      s1_prod_w <= PRODW'(pool_in.out_col) * PRODW'(cfg.step_cols);
    end
  end

  // Window geometry: pad-shifted start, clamped end (unless options bit 1 is set), clipped bounds
  always_comb begin
    ih = CW'(cfg.image_height);
    iw = CW'(cfg.image_width);
    kh = CW'(cfg.window_height);
    kw = CW'(cfg.window_width);
    if (ih > CW'(MAX_H)) ih = CW'(MAX_H);
    if (iw > CW'(MAX_W)) iw = CW'(MAX_W);
    if (kh > CW'(MAX_WINDOW)) kh = CW'(MAX_WINDOW);
    if (kw > CW'(MAX_WINDOW)) kw = CW'(MAX_WINDOW);
    ph  = CW'(cfg.padding[7:4]);
    pw  = CW'(cfg.padding[3:0]);
    phs = CW'(s1_prod_h) - ph;
    pws = CW'(s1_prod_w) - pw;
    phe = phs + kh;
    pwe = pws + kw;
    if (!cfg.options[1]) begin
      if (phe > ih + ph) phe = ih + ph;
      if (pwe > iw + pw) pwe = iw + pw;
    end
    hs = (phs < 0) ? '0 : phs;
    ws = (pws < 0) ? '0 : pws;
    he = (phe < ih) ? phe : ih;
    we = (pwe < iw) ? pwe : iw;
    nonempty = (he > hs) && (we > ws);
    lh = cfg.options[0] ? (phe - phs) : (he - hs);
    lw = cfg.options[0] ? (pwe - pws) : (we - ws);

    cmd_new       = '0;
    cmd_new.query = (s1_func == FUNC_QUERY);
    cmd_new.zero  = !nonempty;
    cmd_new.wr    = s1_wr;
    cmd_new.value = s1_value;
    cmd_new.hs    = HB'(hs);
    cmd_new.he    = HB'(he);
    cmd_new.ws    = WB'(ws);
    cmd_new.we    = WB'(we);
    cmd_new.area  = AREAW'(lh[LENW-1:0]) * AREAW'(lw[LENW-1:0]);
    if (s1_func == FUNC_QUERY) begin
      cmd_new.addr = AW'(AW'(hs) * AW'(MAX_W) + AW'(ws));
    end else begin
      cmd_new.addr = s1_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wptr] <= cmd_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (cmd_pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

  assign cmd_valid = (count != 2'd0);
  assign cmd       = q_mem[rptr];

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> count != 2'd0)
    else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (full && !cmd_pop) |=> count == 2'd2)
    else $error("queue lost an entry while full");

endmodule

// ----- src/avgp_back.sv -----
// Back end: plane store, window sum over cycles, bit-serial rounding divide.
// Depends on avgp_pkg and avgp_out_if.
module avgp_back
  import avgp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  avgp_out_if.source pool_out
);

  localparam logic [NW-1:0] LIM = NW'((64'd1 << (PIXEL_BITS - 1)) - 64'd1);

  back_state_t state, state_next;

  logic [PIXEL_BITS-1:0] mem [MEM_DEPTH];
  logic [PIXEL_BITS-1:0] rdata;
  logic                  rd_en;
  logic                  rd_pend;
  logic                  mem_we;

  logic [HB-1:0]    row, he;
  logic [WB-1:0]    col, ws, we;
  logic [AW-1:0]    addr, row_addr;
  logic [AREAW-1:0] area;
  logic             res_zero;
  logic signed [SUMW-1:0] acc;
  logic             neg;
  logic [NW-1:0]    quo;
  logic [AREAW:0]   rem;
  logic [AREAW+1:0] trial;
  logic [AREAW+1:0] dvs;
  logic [$clog2(NW+1)-1:0] div_cnt;
  logic             col_last, row_last;
  logic [SUMW-1:0]  mag;
  logic [NW-1:0]    q_neg;
  logic [PIXEL_BITS-1:0] sat;

  assign col_last = (WB'(col + 1'b1) == we);
  assign row_last = (HB'(row + 1'b1) == he);
  assign dvs      = {1'b0, area, 1'b0};
  assign trial    = {rem, quo[NW-1]};
  assign mag      = acc[SUMW-1] ? SUMW'(-acc) : SUMW'(acc);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.query) state_next = cmd.zero ? ST_OUT : ST_SUM;
      end
      ST_SUM:   if (col_last && row_last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DIVLD;
      ST_DIVLD: state_next = ST_DIV;
      ST_DIV:   if (div_cnt == ($clog2(NW+1))'(NW - 1)) state_next = ST_OUT;
      ST_OUT:   if (pool_out.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop        = (state == ST_IDLE) && cmd_valid;
    mem_we         = cmd_pop && !cmd.query && cmd.wr;
    rd_en          = (state == ST_SUM);
    pool_out.valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[cmd.addr] <= cmd.value;
    if (rd_en) rdata <= mem[addr];
  end

  // Window walk, accumulate, divide
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.query) begin
      row      <= cmd.hs;
      he       <= cmd.he;
      col      <= cmd.ws;
      ws       <= cmd.ws;
      we       <= cmd.we;
      addr     <= cmd.addr;
      row_addr <= cmd.addr;
      area     <= cmd.area;
      res_zero <= cmd.zero;
      acc      <= '0;
    end else begin
      if (state == ST_SUM) begin
        if (col_last) begin
          col      <= ws;
          row      <= HB'(row + 1'b1);
          row_addr <= AW'(row_addr + AW'(MAX_W));
          addr     <= AW'(row_addr + AW'(MAX_W));
        end else begin
          col  <= WB'(col + 1'b1);
          addr <= AW'(addr + 1'b1);
        end
      end
      if (rd_pend) acc <= acc + SUMW'($signed(rdata));
    end
    if (state == ST_DIVLD) begin
      neg     <= acc[SUMW-1];
      quo     <= {mag, 1'b0} + NW'(area);
      rem     <= '0;
      div_cnt <= '0;
    end else if (state == ST_DIV) begin
      if (trial >= dvs) begin
        rem <= (AREAW+1)'(trial - dvs);
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial[AREAW:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // Saturate the rounded quotient to the pixel range
  always_comb begin
    q_neg = -quo;
    if (neg) begin
      sat = (quo > LIM + 1'b1) ? {1'b1, {(PIXEL_BITS-1){1'b0}}} : q_neg[PIXEL_BITS-1:0];
    end else begin
      sat = (quo > LIM) ? LIM[PIXEL_BITS-1:0] : quo[PIXEL_BITS-1:0];
    end
  end

  assign pool_out.average = res_zero ? '0 : sat;

  a_rd_from_sum: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(state) == ST_SUM)
    else $error("read data without a window read");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !pool_out.ready) |=> state == ST_OUT && $stable(pool_out.average))
    else $error("result dropped while stalled");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == ST_IDLE)
    else $error("command taken while busy");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_cnt < ($clog2(NW+1))'(NW))
    else $error("divider overran");

endmodule

// ----- src/average_pool_2d_core.sv -----
// Average pooling over one stored image plane: load requests fill a 64x64 store of
// signed 16-bit pixels, query requests return the rounded window average.
// Top level; depends on avgp_pkg, avgp_if, avgp_front and avgp_back.
//
// A load request writes one pixel (out-of-store coordinates are dropped) and
// returns nothing. A query request returns one average: the strided window is
// shifted by the padding, clipped to the image, its pixels summed and the sum
// divided by the pool area (clipped area, or padded area when options bit 0 is
// set), rounded to nearest with ties away from zero and saturated. An empty
// clipped window gives 0. Load every pixel a query will cover before querying.
// Flow: the front end takes one request per cycle into a two-entry queue,
// stalling while the queue is full; the back end takes a new command only
// when idle, and on a query reads the covered pixels one at a time (single
// store read port), then runs the one-bit-per-cycle divider (25 steps).
// Configuration may be written only while no request is in flight.
module average_pool_2d_core
  import avgp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  avgp_in_if.sink           pool_in,
  avgp_out_if.source        pool_out
);

  cfg_t cfg;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Configuration registers; writes truncate to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_height  <= 7'd1;
      cfg.image_width   <= 7'd1;
      cfg.window_height <= 5'd1;
      cfg.window_width  <= 5'd1;
      cfg.step_rows     <= 5'd1;
      cfg.step_cols     <= 5'd1;
      cfg.padding       <= 8'd0;
      cfg.options       <= 2'd0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data[6:0];
        REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data[6:0];
        REG_WINDOW_HEIGHT: cfg.window_height <= cfg_data[4:0];
        REG_WINDOW_WIDTH:  cfg.window_width  <= cfg_data[4:0];
        REG_STEP_ROWS:     cfg.step_rows     <= cfg_data[4:0];
        REG_STEP_COLS:     cfg.step_cols     <= cfg_data[4:0];
        REG_PADDING:       cfg.padding       <= cfg_data[7:0];
        REG_OPTIONS:       cfg.options       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Front: accept and classify, hold commands in the queue
  avgp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pool_in   (pool_in),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back: store pixels, sum windows, divide, hold the result until taken
  avgp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .pool_out  (pool_out)
  );

endmodule
